@@ design/pip_pkg.sv @@
// Shared constants and types for the point-in-polygon test.
// Used by pip_cell, pip_edge, point_in_polygon_test and tb_top; depends on nothing.
`default_nettype none
package pip_pkg;
    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 32;
    localparam int IDX_BITS     = $clog2(MAX_VERTICES);
    localparam int CNT_BITS     = 7;
    localparam int STEP_BITS    = $clog2(MAX_VERTICES + 3);
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int PROD_BITS    = 2 * DIFF_BITS;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_TEST  = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic   shift;
        logic   load;
        coord_t x;
        coord_t y;
    } cell_ctrl_t;
endpackage
`default_nettype wire

@@ design/pip_cell.sv @@
// One vertex cell of the rotating vertex ring.
// Depends on pip_pkg.
`default_nettype none
module pip_cell (
    input  wire                  aclk,
    input  pip_pkg::cell_ctrl_t  ctrl,
    input  pip_pkg::coord_t      nb_x,
    input  pip_pkg::coord_t      nb_y,
    output pip_pkg::coord_t      x,
    output pip_pkg::coord_t      y
);
    pip_pkg::coord_t x_reg, y_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            x_reg <= ctrl.x;
            y_reg <= ctrl.y;
        end else if (ctrl.shift) begin
            x_reg <= nb_x;
            y_reg <= nb_y;
        end
    end

    assign x = x_reg;
    assign y = y_reg;
endmodule
`default_nettype wire

@@ design/pip_edge.sv @@
// Three-stage edge crossing evaluator with parity accumulator.
// Depends on pip_pkg.
`default_nettype none
module pip_edge (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              clear,
    input  wire              edge_valid,
    input  pip_pkg::coord_t  xi,
    input  pip_pkg::coord_t  yi,
    input  pip_pkg::coord_t  xj,
    input  pip_pkg::coord_t  yj,
    input  pip_pkg::coord_t  tx,
    input  pip_pkg::coord_t  ty,
    output logic             parity
);
    localparam int DB = pip_pkg::DIFF_BITS;
    localparam int PB = pip_pkg::PROD_BITS;

    logic                 s1_valid_reg, s2_valid_reg;
    logic signed [DB-1:0] dx_reg, dy_reg, ex_reg, ey_reg;
    logic signed [PB-1:0] lhs_reg, rhs_reg;
    logic                 dypos_reg;
    logic                 parity_reg, parity_next;
    logic                 straddle, left;

    assign straddle = (yi > ty) != (yj > ty);

    always_ff @(posedge aclk) begin
        dx_reg    <= DB'(xj) - DB'(xi);
        dy_reg    <= DB'(yj) - DB'(yi);
        ex_reg    <= DB'(tx) - DB'(xi);
        ey_reg    <= DB'(ty) - DB'(yi);
        lhs_reg   <= PB'(ex_reg) * PB'(dy_reg);
        rhs_reg   <= PB'(dx_reg) * PB'(ey_reg);
        dypos_reg <= dy_reg > 0;
    end

    assign left = dypos_reg ? (lhs_reg < rhs_reg) : (rhs_reg < lhs_reg);

    always_comb begin
        parity_next = parity_reg;
        if (clear) begin
            parity_next = 1'b0;
        end else if (s2_valid_reg && left) begin
            parity_next = !parity_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            parity_reg   <= 1'b0;
        end else begin
            s1_valid_reg <= edge_valid && straddle;
            s2_valid_reg <= s1_valid_reg;
            parity_reg   <= parity_next;
        end
    end

    assign parity = parity_reg;
endmodule
`default_nettype wire

@@ design/point_in_polygon_test.sv @@
// Top level of the point-in-polygon test: vertex ring, sequencer, output register.
// Depends on pip_pkg, pip_cell and pip_edge.
//
// Usage: the input channel (s_valid/s_ready) carries one transaction per item.
// mode 0 writes coord_x/coord_y into vertex slot vertex_index and gives no
// result. mode 1 tests the point against the first vertex_count
// vertices (clamped to 64) and gives one inside flag on m_valid/m_ready.
// A test rotates the 64-cell vertex ring once, one vertex per cycle, feeding a
// three-stage edge evaluator; the result register loads at the last step,
// whatever vertex_count is. s_ready is high only while no test runs, so no
// new item is taken until the test finishes.
// A finished result waits in the output register; while the receiver stalls a
// new item may still be taken, but a test finishing meanwhile holds its last
// step until the register is free.
// cfg_wr_en writes vertex_count at once; write it only while idle.
// Reset clears vertex_count, the sequencer and m_valid; vertex slots are
// undefined until written.
`default_nettype none
module point_in_polygon_test (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             cfg_wr_en,
    input  wire  [pip_pkg::CNT_BITS-1:0]    cfg_wr_data,
    input  wire                             s_valid,
    output logic                            s_ready,
    input  wire                             s_mode,
    input  wire  [5:0]                      s_vertex_index,
    input  wire  signed [31:0]              s_coord_x,
    input  wire  signed [31:0]              s_coord_y,
    output logic                            m_valid,
    input  wire                             m_ready,
    output logic                            m_inside_res
);
    localparam int NV = pip_pkg::MAX_VERTICES;
    localparam int SB = pip_pkg::STEP_BITS;
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;
    localparam logic [SB-1:0] LAST_STEP = SB'(NV + 3);

    logic                         state_reg, state_next;
    logic [SB-1:0]                step_reg, step_next;
    logic [pip_pkg::CNT_BITS-1:0] count_reg, n_use;
    logic                         m_valid_reg, m_valid_next;
    logic                         inside_reg;
    pip_pkg::coord_t              tx_reg, ty_reg, px_reg, py_reg, in_x, in_y;
    pip_pkg::coord_t              cx [NV];
    pip_pkg::coord_t              cy [NV];
    logic                         accept, wr, shift, edge_valid, clear, parity, finish;

    assign in_x   = pip_pkg::coord_t'(s_coord_x);
    assign in_y   = pip_pkg::coord_t'(s_coord_y);
    assign s_ready = (state_reg == ST_IDLE);
    assign accept = s_valid && s_ready;
    assign wr     = accept && (s_mode == pip_pkg::MODE_WRITE);
    assign n_use  = (count_reg > pip_pkg::CNT_BITS'(NV)) ? pip_pkg::CNT_BITS'(NV) : count_reg;
    assign shift  = (state_reg == ST_RUN) && (step_reg < SB'(NV));
    assign edge_valid = (state_reg == ST_RUN) &&
                        (((step_reg >= SB'(1)) && (SB'(n_use) > step_reg)) ||
                         ((step_reg == SB'(NV)) && (n_use != '0)));
    assign clear  = accept && (s_mode == pip_pkg::MODE_TEST);
    assign finish = (state_reg == ST_RUN) && (step_reg == LAST_STEP) &&
                    (!m_valid_reg || m_ready);

    genvar k;
    generate
        for (k = 0; k < NV; k++) begin : g_cell
            pip_pkg::cell_ctrl_t ctrl;
            assign ctrl.shift = shift;
            assign ctrl.load  = wr && (s_vertex_index == pip_pkg::IDX_BITS'(k));
            assign ctrl.x     = in_x;
            assign ctrl.y     = in_y;
            pip_cell u_cell (
                .aclk (aclk),
                .ctrl (ctrl),
                .nb_x (cx[(k + 1) % NV]),
                .nb_y (cy[(k + 1) % NV]),
                .x    (cx[k]),
                .y    (cy[k])
            );
        end
    endgenerate

    pip_edge u_edge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear      (clear),
        .edge_valid (edge_valid),
        .xi         (cx[0]),
        .yi         (cy[0]),
        .xj         (px_reg),
        .yj         (py_reg),
        .tx         (tx_reg),
        .ty         (ty_reg),
        .parity     (parity)
    );

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (clear) begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN: begin
                if (finish) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end else if (step_reg != LAST_STEP) begin
                    step_next = step_reg + SB'(1);
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clear) begin
            tx_reg <= in_x;
            ty_reg <= in_y;
        end
        if (shift && (SB'(n_use) > step_reg)) begin
            px_reg <= cx[0];
            py_reg <= cy[0];
        end
        if (finish) begin
            inside_reg <= parity;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_inside_res = inside_reg;
endmodule
`default_nettype wire

@@ design/pip_checker.sv @@
// Port-level checks for point_in_polygon_test, bound to the top level.
// Depends on point_in_polygon_test's ports only.
`default_nettype none
module pip_checker (
    input wire aclk,
    input wire aresetn,
    input wire s_valid,
    input wire s_ready,
    input wire s_mode,
    input wire m_valid,
    input wire m_ready,
    input wire m_inside_res
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_inside_res))
        else $error("stalled result transaction changed");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_mode |=> !s_ready)
        else $error("test did not block input");
    a_write: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_mode |=> s_ready)
        else $error("vertex write blocked input");
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_mode       (s_mode),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_inside_res (m_inside_res)
);
`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for point_in_polygon_test: vertex writes, point tests, count changes.
// Depends on pip_pkg and the point_in_polygon_test RTL; predicts each inside flag locally.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint COORD_LIM = 1800000000;

    logic                         aclk;
    logic                         aresetn;
    logic                         cfg_wr_en;
    logic [pip_pkg::CNT_BITS-1:0] cfg_wr_data;
    logic                         s_valid;
    logic                         s_ready;
    logic                         s_mode;
    logic [5:0]                   s_vertex_index;
    logic signed [31:0]           s_coord_x;
    logic signed [31:0]           s_coord_y;
    logic                         m_valid;
    logic                         m_ready;
    logic                         m_inside_res;

    pip_pkg::coord_t              ring_x [pip_pkg::MAX_VERTICES];
    pip_pkg::coord_t              ring_y [pip_pkg::MAX_VERTICES];
    logic [pip_pkg::CNT_BITS-1:0] poly_count;
    logic                         inside_q [$];
    int                           error_count;
    int                           items_sent;
    int                           send_idle_pct;
    int                           recv_stall_pct;
    bit                           ring_full;

    point_in_polygon_test i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_vertex_index (s_vertex_index),
        .s_coord_x      (s_coord_x),
        .s_coord_y      (s_coord_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_inside_res   (m_inside_res)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic logic crossing_parity(pip_pkg::coord_t tx, pip_pkg::coord_t ty);
        int n;
        int j;
        logic odd;
        logic signed [33:0] dy;
        logic signed [69:0] lhs;
        logic signed [69:0] rhs;
        logic left;
        n = (poly_count > pip_pkg::MAX_VERTICES) ? pip_pkg::MAX_VERTICES : poly_count;
        odd = 1'b0;
        for (int i = 0; i < n; i++) begin
            j = (i == 0) ? n - 1 : i - 1;
            if ((ring_y[i] > ty) != (ring_y[j] > ty)) begin
                dy  = ring_y[j] - ring_y[i];
                lhs = (tx - ring_x[i]) * dy;
                rhs = (ring_x[j] - ring_x[i]) * (ty - ring_y[i]);
                left = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
                if (left) odd = ~odd;
            end
        end
        return odd;
    endfunction

    function automatic pip_pkg::coord_t rand_coord();
        return pip_pkg::coord_t'(longint'($urandom_range(32'd3600000000)) - COORD_LIM);
    endfunction

    function automatic pip_pkg::coord_t near_coord(longint centre, longint radius);
        longint v;
        v = centre + longint'($urandom_range(32'(2 * radius))) - radius;
        if (v > COORD_LIM) v = COORD_LIM;
        if (v < -COORD_LIM) v = -COORD_LIM;
        return pip_pkg::coord_t'(v);
    endfunction

    task automatic send_item(logic mode, logic [5:0] idx, pip_pkg::coord_t x,
                             pip_pkg::coord_t y);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= mode;
        s_vertex_index <= idx;
        s_coord_x      <= x;
        s_coord_y      <= y;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (mode == pip_pkg::MODE_WRITE) begin
            ring_x[idx] = x;
            ring_y[idx] = y;
        end else begin
            inside_q.push_back(crossing_parity(x, y));
        end
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (inside_q.size() != 0) @(posedge aclk);
        repeat (72) @(posedge aclk);
    endtask

    task automatic set_count(int unsigned n);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= pip_pkg::CNT_BITS'(n);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        poly_count = pip_pkg::CNT_BITS'(n);
    endtask

    task automatic test_empty_polygon();
        send_item(pip_pkg::MODE_TEST, 6'd0, pip_pkg::coord_t'(COORD_LIM),
                  pip_pkg::coord_t'(-COORD_LIM));
        send_item(pip_pkg::MODE_TEST, 6'd63, 32'sd0, 32'sd0);
    endtask

    task automatic test_square_extremes();
        send_item(pip_pkg::MODE_WRITE, 6'd0, pip_pkg::coord_t'(-COORD_LIM),
                  pip_pkg::coord_t'(-COORD_LIM));
        send_item(pip_pkg::MODE_WRITE, 6'd1, pip_pkg::coord_t'(COORD_LIM),
                  pip_pkg::coord_t'(-COORD_LIM));
        send_item(pip_pkg::MODE_WRITE, 6'd2, pip_pkg::coord_t'(COORD_LIM),
                  pip_pkg::coord_t'(COORD_LIM));
        send_item(pip_pkg::MODE_WRITE, 6'd3, pip_pkg::coord_t'(-COORD_LIM),
                  pip_pkg::coord_t'(COORD_LIM));
        set_count(4);
        send_item(pip_pkg::MODE_TEST, 6'd0, 32'sd0, 32'sd0);
        send_item(pip_pkg::MODE_TEST, 6'd0, pip_pkg::coord_t'(-COORD_LIM),
                  pip_pkg::coord_t'(-COORD_LIM));
        send_item(pip_pkg::MODE_TEST, 6'd0, pip_pkg::coord_t'(COORD_LIM),
                  pip_pkg::coord_t'(COORD_LIM));
        send_item(pip_pkg::MODE_TEST, 6'd0, pip_pkg::coord_t'(COORD_LIM - 1), 32'sd0);
        send_item(pip_pkg::MODE_TEST, 6'd0, pip_pkg::coord_t'(1 - COORD_LIM), 32'sd0);
        send_item(pip_pkg::MODE_TEST, 6'd0, pip_pkg::coord_t'(1 - COORD_LIM),
                  pip_pkg::coord_t'(COORD_LIM - 1));
    endtask

    task automatic test_degenerate_counts();
        set_count(1);
        send_item(pip_pkg::MODE_TEST, 6'd0, 32'sd0, 32'sd0);
        set_count(2);
        send_item(pip_pkg::MODE_TEST, 6'd0, 32'sd0, 32'sd0);
        set_count(3);
        send_item(pip_pkg::MODE_TEST, 6'd0, pip_pkg::coord_t'(COORD_LIM / 2), -32'sd5);
    endtask

    task automatic polygon_round();
        int unsigned n;
        int unsigned tests;
        int unsigned pick;
        int unsigned k;
        longint cx;
        longint cy;
        longint r;
        cx = longint'($urandom_range(32'd2000000000)) - 1000000000;
        cy = longint'($urandom_range(32'd2000000000)) - 1000000000;
        r  = ($urandom_range(3) == 0) ? 2000 : longint'($urandom_range(32'd700000000)) + 1;
        pick = $urandom_range(99);
        if (!ring_full) n = 64;
        else if (pick < 65) n = $urandom_range(12, 3);
        else if (pick < 80) n = $urandom_range(64, 13);
        else if (pick < 90) n = 64;
        else if (pick < 95) n = $urandom_range(127, 65);
        else n = $urandom_range(1, 0);
        if (n <= 64) begin
            for (int i = 0; i < n; i++)
                send_item(pip_pkg::MODE_WRITE, 6'(i), near_coord(cx, r), near_coord(cy, r));
        end
        if (n == 64) ring_full = 1'b1;
        if ($urandom_range(3) == 0) n = 127;
        set_count(n);
        tests = $urandom_range(20, 8);
        for (int t = 0; t < tests; t++) begin
            pick = $urandom_range(99);
            k = $urandom_range(((n > 64) ? 64 : (n == 0 ? 1 : n)) - 1);
            if (pick < 10)
                send_item(pip_pkg::MODE_TEST, 6'($urandom), rand_coord(), rand_coord());
            else if (pick < 25)
                send_item(pip_pkg::MODE_TEST, 6'($urandom), near_coord(cx, r), ring_y[k]);
            else if (pick < 30)
                send_item(pip_pkg::MODE_TEST, 6'($urandom), ring_x[k], ring_y[k]);
            else if (pick < 35 && n < 64)
                send_item(pip_pkg::MODE_WRITE, 6'($urandom_range(63, n)), rand_coord(),
                          rand_coord());
            else
                send_item(pip_pkg::MODE_TEST, 6'($urandom), near_coord(cx, r + r / 4),
                          near_coord(cy, r + r / 4));
        end
    endtask

    task automatic test_random_polygons(int idle_pct, int stall_pct, int target);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (items_sent < target) polygon_round();
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (inside_q.size() == 0) begin
                error_count++;
                if (error_count <= 10) $display("unexpected result inside_res=%0b", m_inside_res);
            end else begin
                if (m_inside_res !== inside_q[0]) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("inside_res mismatch: expected %0b, got %0b",
                                 inside_q[0], m_inside_res);
                end
                void'(inside_q.pop_front());
            end
        end
    end

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_mode         = pip_pkg::MODE_WRITE;
        s_vertex_index = '0;
        s_coord_x      = '0;
        s_coord_y      = '0;
        m_ready        = 1'b1;
        poly_count     = '0;
        error_count    = 0;
        items_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        ring_full      = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_empty_polygon();
        test_square_extremes();
        test_degenerate_counts();
        test_random_polygons(0, 0, 250);
        test_random_polygons(50, 0, 480);
        test_random_polygons(0, 50, 710);
        test_random_polygons(28, 28, 930);
        set_count(127);
        send_item(pip_pkg::MODE_TEST, 6'd0, 32'sd0, 32'sd0);
        set_count(0);
        send_item(pip_pkg::MODE_TEST, 6'd0, 32'sd0, 32'sd0);

        wait_idle();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
design/pip_pkg.sv
design/pip_cell.sv
design/pip_edge.sv
design/point_in_polygon_test.sv
design/pip_checker.sv
sim/tb_top.sv
